### rtl/core/rrc_pkg.sv
`timescale 1ns / 1ps
package rrc_pkg;

   localparam int MAX_TARGETS = 32;
   localparam int IDX_W       = $clog2(MAX_TARGETS);
   localparam int CNT_W       = $clog2(MAX_TARGETS + 1);

   localparam logic [16:0] ADDR_SPACE_END = 17'h10000;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_FETCH = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED = 3'd0,
      KIND_REJECTED = 3'd1,
      KIND_HEADER   = 3'd2,
      KIND_SLICE    = 3'd3,
      KIND_NO_MORE  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      CSR_MAX_GAP   = 3'd0,
      CSR_MAX_COILS = 3'd1,
      CSR_MAX_DISC  = 3'd2,
      CSR_MAX_HOLD  = 3'd3,
      CSR_MAX_INPUT = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_LOADING,
      PH_NEWRUN,
      PH_HEADER,
      PH_SLICING,
      PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SORT_RD,
      ST_SORT_KEY,
      ST_SORT_SCAN,
      ST_DISPATCH,
      ST_RUN_FIRST,
      ST_RUN_SCAN,
      ST_SLICE_RD,
      ST_SLICE_CHK,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [7:0]  unit;
      logic [1:0]  rtype;
      logic [15:0] start;
      logic [16:0] end_addr;
   } tgt_type;

   typedef struct packed {
      tgt_type          tgt;
      logic [IDX_W-1:0] idx;
   } srt_type;

   typedef struct packed {
      logic [10:0] slice_length;
      logic [15:0] offset_in_target;
      logic [10:0] offset_in_plan;
      logic [4:0]  target_number;
      logic [10:0] plan_quantity;
      logic [15:0] plan_start;
      logic [1:0]  plan_type;
      logic [7:0]  plan_unit;
   } rsp_data_type;

endpackage

### rtl/core/rrc_ram.sv
`timescale 1ns / 1ps
module rrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/read_request_coalescer.sv
`timescale 1ns / 1ps
// Channel   Direction  tdata fields (low bit up)                       tuser
// req_*     in         unit_id, register_type, start_address,          operation
//                      address_count (6 zero pad bits)
// rsp_*     out        plan_unit, plan_type, plan_start, plan_quantity, kind
//                      target_number, offset_in_plan, offset_in_target,
//                      slice_length
// csr_*     in         write enable, register index, 16-bit write data  -
//
// The first fetch after loading ranks each target against all others through
// one RAM read port. Fetches skip targets that miss the chunk, step chunk by
// chunk and gather each run member by member. Reset is synchronous; both RAMs
// need no clearing. A stalled result sits in the output register while the
// next word is taken and worked on.
module read_request_coalescer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // unit_id, register_type, start_address, address_count
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // plan_unit, plan_type, plan_start, plan_quantity,
                                    // target_number, offset_in_plan, offset_in_target,
                                    // slice_length
   output logic [2:0]  rsp_tuser,   // kind
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IW = rrc_pkg::IDX_W;
   localparam int CW = rrc_pkg::CNT_W;

   rrc_pkg::state_type state_ff, state_in;
   rrc_pkg::phase_type phase_ff, phase_in;

   logic [15:0] gap_ff;
   logic [10:0] mc0_ff, mc1_ff;
   logic [6:0]  mc2_ff, mc3_ff;

   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] sort_i_ff, sort_i_in;
   logic [CW-1:0] sort_j_ff, sort_j_in;
   logic [IW-1:0] rank_ff, rank_in;
   rrc_pkg::tgt_type key_ff, key_in;

   logic [7:0]  run_unit_ff, run_unit_in;
   logic [1:0]  run_type_ff, run_type_in;
   logic [15:0] run_start_ff, run_start_in;
   logic [16:0] run_end_ff, run_end_in;
   logic [CW-1:0] run_first_ff, run_first_in;
   logic [CW-1:0] run_last_ff, run_last_in;
   logic [CW-1:0] run_next_ff, run_next_in;
   logic [16:0] chunk_ff, chunk_in;
   logic [CW-1:0] slice_ff, slice_in;

   rrc_pkg::kind_type     res_kind_ff, res_kind_in;
   rrc_pkg::rsp_data_type res_ff, res_in;
   logic                  out_valid_ff, out_valid_in;
   logic [2:0]            out_kind_ff, out_kind_in;
   rrc_pkg::rsp_data_type out_ff, out_in;

   logic           tgt_we;
   logic [IW-1:0]  tgt_waddr, tgt_raddr;
   rrc_pkg::tgt_type tgt_wdata, tgt_rdata;
   logic           srt_we;
   logic [IW-1:0]  srt_waddr, srt_raddr;
   rrc_pkg::srt_type srt_wdata, srt_rdata;

   logic          req_fire;
   rrc_pkg::op_type req_op;
   logic [7:0]    req_unit;
   logic [1:0]    req_type;
   logic [15:0]   req_start;
   logic [15:0]   req_count;
   logic [16:0]   add_sum;
   logic [10:0]   max_raw, chunk_max;
   logic [17:0]   chunk_sum;
   logic [16:0]   chunk_end;
   logic [17:0]   gap_limit;
   logic          run_join;
   logic          sort_less;
   logic [IW-1:0] sort_rank_next;
   logic [CW-1:0] sort_dj;
   logic [16:0]   sl_os, sl_oe;
   logic          can_load;

   assign req_tready = (state_ff == rrc_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = rrc_pkg::op_type'(req_tuser);
   assign req_unit   = req_tdata[7:0];
   assign req_type   = req_tdata[9:8];
   assign req_start  = req_tdata[25:10];
   assign req_count  = req_tdata[41:26];
   assign add_sum    = {1'b0, req_start} + {1'b0, req_count};
   assign can_load   = !out_valid_ff || rsp_tready;

   rrc_ram #(.WIDTH($bits(rrc_pkg::tgt_type)), .DEPTH(rrc_pkg::MAX_TARGETS)) u_tgt_ram (
      .clock (clock),
      .we    (tgt_we),
      .waddr (tgt_waddr),
      .wdata (tgt_wdata),
      .raddr (tgt_raddr),
      .rdata (tgt_rdata)
   );

   rrc_ram #(.WIDTH($bits(rrc_pkg::srt_type)), .DEPTH(rrc_pkg::MAX_TARGETS)) u_srt_ram (
      .clock (clock),
      .we    (srt_we),
      .waddr (srt_waddr),
      .wdata (srt_wdata),
      .raddr (srt_raddr),
      .rdata (srt_rdata)
   );

   // chunk limit of the current run's type; zero acts as one
   always_comb begin
      case (run_type_ff)
         2'd0:    max_raw = mc0_ff;
         2'd1:    max_raw = mc1_ff;
         2'd2:    max_raw = {4'd0, mc2_ff};
         default: max_raw = {4'd0, mc3_ff};
      endcase
      chunk_max = (max_raw == 11'd0) ? 11'd1 : max_raw;
   end

   assign chunk_sum = {1'b0, chunk_ff} + {7'd0, chunk_max};
   assign chunk_end = (chunk_sum > {1'b0, run_end_ff}) ? run_end_ff : chunk_sum[16:0];
   assign gap_limit = {1'b0, run_end_ff} + {2'd0, gap_ff};
   assign run_join  = (run_next_ff < total_ff)
                      && (srt_rdata.tgt.unit == run_unit_ff)
                      && (srt_rdata.tgt.rtype == run_type_ff)
                      && ({2'd0, srt_rdata.tgt.start} <= gap_limit);

   assign sort_dj   = sort_j_ff - CW'(1);
   assign sort_less = ({tgt_rdata.unit, tgt_rdata.rtype, tgt_rdata.start}
                       < {key_ff.unit, key_ff.rtype, key_ff.start})
                      || (({tgt_rdata.unit, tgt_rdata.rtype, tgt_rdata.start}
                           == {key_ff.unit, key_ff.rtype, key_ff.start})
                          && (sort_dj < sort_i_ff));
   assign sort_rank_next = rank_ff + IW'(sort_less);

   assign sl_os = ({1'b0, srt_rdata.tgt.start} > chunk_ff)
                  ? {1'b0, srt_rdata.tgt.start} : chunk_ff;
   assign sl_oe = (srt_rdata.tgt.end_addr < chunk_end) ? srt_rdata.tgt.end_addr : chunk_end;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrc_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  rrc_pkg::OP_CLEAR, rrc_pkg::OP_ADD: state_in = rrc_pkg::ST_EMIT;
                  rrc_pkg::OP_FETCH: state_in = (phase_ff == rrc_pkg::PH_LOADING)
                                                ? rrc_pkg::ST_SORT_RD : rrc_pkg::ST_DISPATCH;
                  default: state_in = rrc_pkg::ST_IDLE;
               endcase
            end
         end
         rrc_pkg::ST_SORT_RD:
            state_in = (sort_i_ff == total_ff) ? rrc_pkg::ST_DISPATCH : rrc_pkg::ST_SORT_KEY;
         rrc_pkg::ST_SORT_KEY: state_in = rrc_pkg::ST_SORT_SCAN;
         rrc_pkg::ST_SORT_SCAN:
            if (sort_j_ff == total_ff) begin
               state_in = rrc_pkg::ST_SORT_RD;
            end
         rrc_pkg::ST_DISPATCH: begin
            case (phase_ff)
               rrc_pkg::PH_NEWRUN:
                  state_in = (run_next_ff >= total_ff) ? rrc_pkg::ST_EMIT
                                                       : rrc_pkg::ST_RUN_FIRST;
               rrc_pkg::PH_SLICING: state_in = rrc_pkg::ST_SLICE_RD;
               default: state_in = rrc_pkg::ST_EMIT;
            endcase
         end
         rrc_pkg::ST_RUN_FIRST: state_in = rrc_pkg::ST_RUN_SCAN;
         rrc_pkg::ST_RUN_SCAN:
            if (!run_join) begin
               state_in = rrc_pkg::ST_DISPATCH;
            end
         rrc_pkg::ST_SLICE_RD:
            state_in = (slice_ff < run_last_ff) ? rrc_pkg::ST_SLICE_CHK : rrc_pkg::ST_DISPATCH;
         rrc_pkg::ST_SLICE_CHK:
            state_in = (sl_os < sl_oe) ? rrc_pkg::ST_EMIT : rrc_pkg::ST_SLICE_RD;
         rrc_pkg::ST_EMIT:
            if (can_load) begin
               state_in = rrc_pkg::ST_IDLE;
            end
         default: state_in = rrc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      total_in     = total_ff;
      sort_i_in    = sort_i_ff;
      sort_j_in    = sort_j_ff;
      rank_in      = rank_ff;
      key_in       = key_ff;
      run_unit_in  = run_unit_ff;
      run_type_in  = run_type_ff;
      run_start_in = run_start_ff;
      run_end_in   = run_end_ff;
      run_first_in = run_first_ff;
      run_last_in  = run_last_ff;
      run_next_in  = run_next_ff;
      chunk_in     = chunk_ff;
      slice_in     = slice_ff;
      res_kind_in  = res_kind_ff;
      res_in       = res_ff;
      tgt_we       = 1'b0;
      tgt_waddr    = total_ff[IW-1:0];
      tgt_wdata    = '{unit: req_unit, rtype: req_type, start: req_start,
                       end_addr: (add_sum > rrc_pkg::ADDR_SPACE_END)
                                 ? rrc_pkg::ADDR_SPACE_END : add_sum};
      tgt_raddr    = '0;
      srt_we       = 1'b0;
      srt_waddr    = sort_rank_next;
      srt_wdata    = '{tgt: key_ff, idx: sort_i_ff[IW-1:0]};
      srt_raddr    = '0;

      case (state_ff)
         rrc_pkg::ST_IDLE: begin
            if (req_fire) begin
               res_in = '0;
               case (req_op)
                  rrc_pkg::OP_CLEAR: begin
                     total_in    = '0;
                     phase_in    = rrc_pkg::PH_LOADING;
                     res_kind_in = rrc_pkg::KIND_ACCEPTED;
                  end
                  rrc_pkg::OP_ADD: begin
                     if (total_ff >= CW'(rrc_pkg::MAX_TARGETS)) begin
                        res_kind_in = rrc_pkg::KIND_REJECTED;
                     end else begin
                        tgt_we               = 1'b1;
                        res_kind_in          = rrc_pkg::KIND_ACCEPTED;
                        res_in.target_number = 5'(total_ff);
                        total_in             = total_ff + CW'(1);
                        phase_in             = rrc_pkg::PH_LOADING;
                     end
                  end
                  rrc_pkg::OP_FETCH: begin
                     sort_i_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         rrc_pkg::ST_SORT_RD: begin
            if (sort_i_ff == total_ff) begin
               phase_in    = rrc_pkg::PH_NEWRUN;
               run_next_in = '0;
            end else begin
               tgt_raddr = sort_i_ff[IW-1:0];
            end
         end
         rrc_pkg::ST_SORT_KEY: begin
            key_in    = tgt_rdata;
            tgt_raddr = '0;
            sort_j_in = CW'(1);
            rank_in   = '0;
         end
         rrc_pkg::ST_SORT_SCAN: begin
            // data in hand belongs to entry sort_j - 1
            rank_in = sort_rank_next;
            if (sort_j_ff == total_ff) begin
               srt_we    = 1'b1;
               sort_i_in = sort_i_ff + CW'(1);
            end else begin
               tgt_raddr = sort_j_ff[IW-1:0];
               sort_j_in = sort_j_ff + CW'(1);
            end
         end
         rrc_pkg::ST_DISPATCH: begin
            res_in = '0;
            case (phase_ff)
               rrc_pkg::PH_NEWRUN: begin
                  if (run_next_ff >= total_ff) begin
                     phase_in    = rrc_pkg::PH_DONE;
                     res_kind_in = rrc_pkg::KIND_NO_MORE;
                  end else begin
                     srt_raddr = run_next_ff[IW-1:0];
                  end
               end
               rrc_pkg::PH_HEADER: begin
                  res_kind_in          = rrc_pkg::KIND_HEADER;
                  res_in.plan_unit     = run_unit_ff;
                  res_in.plan_type     = run_type_ff;
                  res_in.plan_start    = chunk_ff[15:0];
                  res_in.plan_quantity = 11'(chunk_end - chunk_ff);
                  slice_in             = run_first_ff;
                  phase_in             = rrc_pkg::PH_SLICING;
               end
               rrc_pkg::PH_SLICING: ;
               default: res_kind_in = rrc_pkg::KIND_NO_MORE;
            endcase
         end
         rrc_pkg::ST_RUN_FIRST: begin
            run_unit_in  = srt_rdata.tgt.unit;
            run_type_in  = srt_rdata.tgt.rtype;
            run_start_in = srt_rdata.tgt.start;
            run_end_in   = srt_rdata.tgt.end_addr;
            chunk_in     = {1'b0, srt_rdata.tgt.start};
            run_first_in = run_next_ff;
            run_next_in  = run_next_ff + CW'(1);
            srt_raddr    = IW'(run_next_ff + CW'(1));
         end
         rrc_pkg::ST_RUN_SCAN: begin
            if (run_join) begin
               if (srt_rdata.tgt.end_addr > run_end_ff) begin
                  run_end_in = srt_rdata.tgt.end_addr;
               end
               run_next_in = run_next_ff + CW'(1);
               srt_raddr   = IW'(run_next_ff + CW'(1));
            end else begin
               run_last_in = run_next_ff;
               phase_in    = ({1'b0, run_start_ff} < run_end_ff)
                             ? rrc_pkg::PH_HEADER : rrc_pkg::PH_NEWRUN;
            end
         end
         rrc_pkg::ST_SLICE_RD: begin
            if (slice_ff < run_last_ff) begin
               srt_raddr = slice_ff[IW-1:0];
               slice_in  = slice_ff + CW'(1);
            end else begin
               chunk_in = chunk_sum[16:0];
               phase_in = (chunk_sum < {1'b0, run_end_ff})
                          ? rrc_pkg::PH_HEADER : rrc_pkg::PH_NEWRUN;
            end
         end
         rrc_pkg::ST_SLICE_CHK: begin
            res_in                  = '0;
            res_kind_in             = rrc_pkg::KIND_SLICE;
            res_in.plan_unit        = run_unit_ff;
            res_in.plan_type        = run_type_ff;
            res_in.plan_start       = chunk_ff[15:0];
            res_in.plan_quantity    = 11'(chunk_end - chunk_ff);
            res_in.target_number    = 5'(srt_rdata.idx);
            res_in.offset_in_plan   = 11'(sl_os - chunk_ff);
            res_in.offset_in_target = 16'(sl_os - {1'b0, srt_rdata.tgt.start});
            res_in.slice_length     = 11'(sl_oe - sl_os);
         end
         default: ;
      endcase
   end

   // output register: load when empty or being drained
   always_comb begin
      out_in       = out_ff;
      out_kind_in  = out_kind_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if ((state_ff == rrc_pkg::ST_EMIT) && can_load) begin
         out_in       = res_ff;
         out_kind_in  = res_kind_ff;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrc_pkg::ST_IDLE;
         phase_ff     <= rrc_pkg::PH_LOADING;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
         gap_ff       <= '0;
         mc0_ff       <= 11'd2000;
         mc1_ff       <= 11'd2000;
         mc2_ff       <= 7'd125;
         mc3_ff       <= 7'd125;
         run_unit_ff  <= '0;
         run_type_ff  <= '0;
         run_start_ff <= '0;
         run_end_ff   <= '0;
         run_first_ff <= '0;
         run_last_ff  <= '0;
         run_next_ff  <= '0;
         chunk_ff     <= '0;
         slice_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
         run_unit_ff  <= run_unit_in;
         run_type_ff  <= run_type_in;
         run_start_ff <= run_start_in;
         run_end_ff   <= run_end_in;
         run_first_ff <= run_first_in;
         run_last_ff  <= run_last_in;
         run_next_ff  <= run_next_in;
         chunk_ff     <= chunk_in;
         slice_ff     <= slice_in;
         if (csr_we) begin
            case (rrc_pkg::csr_index_type'(csr_index))
               rrc_pkg::CSR_MAX_GAP:   gap_ff <= csr_wdata;
               rrc_pkg::CSR_MAX_COILS: mc0_ff <= csr_wdata[10:0];
               rrc_pkg::CSR_MAX_DISC:  mc1_ff <= csr_wdata[10:0];
               rrc_pkg::CSR_MAX_HOLD:  mc2_ff <= csr_wdata[6:0];
               rrc_pkg::CSR_MAX_INPUT: mc3_ff <= csr_wdata[6:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sort_i_ff   <= sort_i_in;
      sort_j_ff   <= sort_j_in;
      rank_ff     <= rank_in;
      key_ff      <= key_in;
      res_kind_ff <= res_kind_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
      out_kind_ff <= out_kind_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = out_kind_ff;

endmodule

### rtl/core/rrc_checker.sv
`timescale 1ns / 1ps
module rrc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [47:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        csr_we,
   input logic [2:0]  csr_index,
   input logic [15:0] csr_wdata
);

   // hold a result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= 3'(rrc_pkg::KIND_NO_MORE)))
      else $error("undefined result kind");

   // only headers and slices carry a plan; the target index is the lone field of an add
   a_plain_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == 3'(rrc_pkg::KIND_ACCEPTED)
                     || rsp_tuser == 3'(rrc_pkg::KIND_REJECTED)
                     || rsp_tuser == 3'(rrc_pkg::KIND_NO_MORE))
      |-> (rsp_tdata[36:0] == '0) && (rsp_tdata[79:42] == '0))
      else $error("plan fields set on a non-plan word");

   a_header_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == 3'(rrc_pkg::KIND_HEADER))
      |-> (rsp_tdata[79:37] == '0) && (rsp_tdata[36:26] != 11'd0))
      else $error("bad plan header word");

endmodule

bind read_request_coalescer rrc_checker u_rrc_checker (.*);

### sim/tb_read_request_coalescer.sv
`timescale 1ns / 1ps
module tb_read_request_coalescer;

   typedef struct {
      rrc_pkg::kind_type     kind;
      rrc_pkg::rsp_data_type d;
   } plan_word_type;

   class plan_scoreboard;
      int unsigned tg_unit[rrc_pkg::MAX_TARGETS], tg_type[rrc_pkg::MAX_TARGETS];
      int unsigned tg_start[rrc_pkg::MAX_TARGETS], tg_end[rrc_pkg::MAX_TARGETS];
      int unsigned order[rrc_pkg::MAX_TARGETS];
      int unsigned total, run_start, run_end, run_first, run_last, run_next;
      int unsigned chunk, slice_pos, gap;
      int unsigned max_cnt[4];
      rrc_pkg::phase_type ph;
      plan_word_type pending[$];
      int errors;

      function new();
         total = 0; ph = rrc_pkg::PH_LOADING; gap = 0; errors = 0;
         run_start = 0; run_end = 0; run_first = 0; run_last = 0; run_next = 0;
         chunk = 0; slice_pos = 0;
         max_cnt[0] = 2000; max_cnt[1] = 2000; max_cnt[2] = 125; max_cnt[3] = 125;
      endfunction

      function void write_csr(rrc_pkg::csr_index_type idx, int unsigned v);
         case (idx)
            rrc_pkg::CSR_MAX_GAP:   gap = v & 16'hFFFF;
            rrc_pkg::CSR_MAX_COILS: max_cnt[0] = v & 11'h7FF;
            rrc_pkg::CSR_MAX_DISC:  max_cnt[1] = v & 11'h7FF;
            rrc_pkg::CSR_MAX_HOLD:  max_cnt[2] = v & 7'h7F;
            rrc_pkg::CSR_MAX_INPUT: max_cnt[3] = v & 7'h7F;
            default: ;
         endcase
      endfunction

      function int unsigned key_of(int unsigned i);
         return (tg_unit[i] << 18) | (tg_type[i] << 16) | tg_start[i];
      endfunction

      function int unsigned limit_of(int unsigned t);
         return max_cnt[t] == 0 ? 1 : max_cnt[t];
      endfunction

      function void sort_store();
         int unsigned i, j, v;
         for (i = 0; i < total; i++) order[i] = i;
         for (i = 1; i < total; i++) begin
            v = order[i];
            j = i;
            while (j > 0 && key_of(order[j-1]) > key_of(v)) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = v;
         end
      endfunction

      function void gather_run();
         int unsigned f, t;
         f = order[run_next];
         run_first = run_next;
         run_start = tg_start[f];
         run_end = tg_end[f];
         run_next++;
         while (run_next < total) begin
            t = order[run_next];
            if (tg_unit[t] != tg_unit[f] || tg_type[t] != tg_type[f]) break;
            if (int'(tg_start[t]) - int'(run_end) > int'(gap)) break;
            if (tg_end[t] > run_end) run_end = tg_end[t];
            run_next++;
         end
         run_last = run_next;
         chunk = run_start;
      endfunction

      function void fill_plan(ref plan_word_type w);
         int unsigned f, ce;
         f = order[run_first];
         ce = chunk + limit_of(tg_type[f]);
         if (ce > run_end) ce = run_end;
         w.d.plan_unit = 8'(tg_unit[f]);
         w.d.plan_type = 2'(tg_type[f]);
         w.d.plan_start = 16'(chunk);
         w.d.plan_quantity = 11'(ce - chunk);
      endfunction

      function void next_plan_word(ref plan_word_type w);
         int unsigned m, ce, idx, os, oe;
         if (ph == rrc_pkg::PH_LOADING) begin
            sort_store();
            run_next = 0;
            ph = rrc_pkg::PH_NEWRUN;
         end
         forever begin
            if (ph == rrc_pkg::PH_NEWRUN) begin
               if (run_next >= total) ph = rrc_pkg::PH_DONE;
               else begin
                  gather_run();
                  if (chunk < run_end) ph = rrc_pkg::PH_HEADER;
                  continue;
               end
            end
            if (ph == rrc_pkg::PH_DONE) begin
               w.kind = rrc_pkg::KIND_NO_MORE;
               return;
            end
            if (ph == rrc_pkg::PH_HEADER) begin
               w.kind = rrc_pkg::KIND_HEADER;
               fill_plan(w);
               slice_pos = run_first;
               ph = rrc_pkg::PH_SLICING;
               return;
            end
            m = limit_of(tg_type[order[run_first]]);
            ce = chunk + m;
            if (ce > run_end) ce = run_end;
            while (slice_pos < run_last) begin
               idx = order[slice_pos];
               slice_pos++;
               os = tg_start[idx] > chunk ? tg_start[idx] : chunk;
               oe = tg_end[idx] < ce ? tg_end[idx] : ce;
               if (os < oe) begin
                  w.kind = rrc_pkg::KIND_SLICE;
                  fill_plan(w);
                  w.d.target_number = 5'(idx);
                  w.d.offset_in_plan = 11'(os - chunk);
                  w.d.offset_in_target = 16'(os - tg_start[idx]);
                  w.d.slice_length = 11'(oe - os);
                  return;
               end
            end
            chunk += m;
            ph = (chunk < run_end) ? rrc_pkg::PH_HEADER : rrc_pkg::PH_NEWRUN;
         end
      endfunction

      function void note_request(rrc_pkg::op_type op, logic [47:0] data);
         plan_word_type w;
         int unsigned e;
         if (op == rrc_pkg::OP_NONE) return;
         w.kind = rrc_pkg::KIND_ACCEPTED;
         w.d = '0;
         if (op == rrc_pkg::OP_CLEAR) begin
            total = 0;
            ph = rrc_pkg::PH_LOADING;
         end else if (op == rrc_pkg::OP_ADD) begin
            if (total >= rrc_pkg::MAX_TARGETS) w.kind = rrc_pkg::KIND_REJECTED;
            else begin
               tg_unit[total] = data[7:0];
               tg_type[total] = data[9:8];
               tg_start[total] = data[25:10];
               e = data[25:10] + data[41:26];
               tg_end[total] = e > 65536 ? 65536 : e;
               w.d.target_number = 5'(total);
               total++;
               ph = rrc_pkg::PH_LOADING;
            end
         end else
            next_plan_word(w);
         pending.push_back(w);
      endfunction

      function void field(string name, int unsigned exp, int unsigned act);
         if (exp != act) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            errors++;
         end
      endfunction

      function void check_response(logic [2:0] kind, logic [79:0] data);
         plan_word_type w;
         rrc_pkg::rsp_data_type a;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word, kind %0d data %h", $time, kind, data);
            errors++;
            return;
         end
         w = pending.pop_front();
         a = data;
         field("kind", w.kind, kind);
         field("plan_unit", w.d.plan_unit, a.plan_unit);
         field("plan_type", w.d.plan_type, a.plan_type);
         field("plan_start", w.d.plan_start, a.plan_start);
         field("plan_quantity", w.d.plan_quantity, a.plan_quantity);
         field("target_number", w.d.target_number, a.target_number);
         field("offset_in_plan", w.d.offset_in_plan, a.offset_in_plan);
         field("offset_in_target", w.d.offset_in_target, a.offset_in_target);
         field("slice_length", w.d.slice_length, a.slice_length);
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   plan_scoreboard sb = new();
   int sent;
   int burst_left;
   int unsigned unit_pool[2];

   read_request_coalescer dut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: stall pattern switches mode every stretch
   initial begin
      int mode, left, cnt;
      rsp_tready = 0;
      mode = 0; left = 0; cnt = 0;
      forever begin
         @(posedge clock);
         if (left == 0) begin
            mode = $urandom_range(3);
            left = $urandom_range(20, 300);
         end
         left--;
         cnt++;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= cnt[0];
            2: rsp_tready <= ($urandom_range(99) < 60);
            default: rsp_tready <= ($urandom_range(99) < 8);
         endcase
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);

   task automatic send_word(rrc_pkg::op_type op, logic [7:0] unit, logic [1:0] rtype,
                            logic [15:0] start, logic [15:0] count);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(3) == 0) burst_left = 200;
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'b0, count, start, rtype, unit};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, {6'b0, count, start, rtype, unit});
      if (op != rrc_pkg::OP_NONE) sent++;
      // keep valid high into the next word; the next call drives new content
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_regs(int unsigned gap, int unsigned c0, int unsigned c1,
                             int unsigned c2, int unsigned c3);
      int unsigned v[5];
      v = '{gap, c0, c1, c2, c3};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_index <= rrc_pkg::csr_index_type'(i);
         csr_wdata <= 16'(v[i]);
         sb.write_csr(rrc_pkg::csr_index_type'(i), v[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_noise(rrc_pkg::op_type op);
      send_word(op, 8'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic add_random();
      logic [7:0]  unit;
      logic [15:0] start, count;
      int r;
      r = $urandom_range(99);
      unit = (r < 85) ? 8'(unit_pool[$urandom_range(1)]) : 8'($urandom_range(255));
      start = (r < 70) ? 16'(1000 + $urandom_range(600)) : 16'($urandom_range(65535));
      if (r > 92) start = 16'(16'hFFFF - $urandom_range(100));
      count = 16'($urandom_range(1, 200));
      if ($urandom_range(9) == 0) count = 16'($urandom_range(65535));
      send_word(rrc_pkg::OP_ADD, unit, 2'($urandom_range(3)), start, count);
   endtask

   initial begin
      int n, k;
      reset = 1;
      req_tvalid = 0; req_tdata = '0; req_tuser = rrc_pkg::OP_NONE;
      csr_we = 0; csr_index = rrc_pkg::CSR_MAX_GAP; csr_wdata = '0;
      sent = 0; burst_left = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: clipping, empty target, extremes, overlap, noise
      write_regs(4, 10, 2000, 1, 125);
      send_word(rrc_pkg::OP_CLEAR, 0, 0, 0, 0);
      send_word(rrc_pkg::OP_ADD, 8'd255, 2'd3, 16'hFFFF, 16'hFFFF);
      send_word(rrc_pkg::OP_ADD, 8'd0, 2'd0, 16'd0, 16'd0);
      send_word(rrc_pkg::OP_ADD, 8'd0, 2'd0, 16'd2, 16'd15);
      send_word(rrc_pkg::OP_ADD, 8'd0, 2'd0, 16'd5, 16'd3);
      send_word(rrc_pkg::OP_ADD, 8'd0, 2'd0, 16'd22, 16'd4);
      send_word(rrc_pkg::OP_ADD, 8'd0, 2'd2, 16'd100, 16'd3);
      send_word(rrc_pkg::OP_NONE, 8'hAA, 2'd1, 16'h5555, 16'hAAAA);
      for (int i = 0; i < 10; i++) send_word(rrc_pkg::OP_FETCH, 0, 0, 0, 0);
      send_word(rrc_pkg::OP_ADD, 8'd0, 2'd1, 16'd3, 16'd1);
      for (int i = 0; i < 8; i++) send_word(rrc_pkg::OP_FETCH, 0, 0, 0, 0);
      drain();
      write_regs(0, 0, 0, 0, 0);
      send_word(rrc_pkg::OP_FETCH, 0, 0, 0, 0);
      send_word(rrc_pkg::OP_FETCH, 0, 0, 0, 0);

      while (sent < 450) begin
         if ($urandom_range(3) == 0) begin
            drain();
            case ($urandom_range(3))
               0: write_regs(0, 1, 1, 1, 1);
               1: write_regs(65535, 2000, 2000, 125, 125);
               default: write_regs($urandom_range(50), $urandom_range(1, 2000),
                                   $urandom_range(1, 2000), $urandom_range(1, 125),
                                   $urandom_range(1, 127));
            endcase
         end
         unit_pool[0] = $urandom_range(255);
         unit_pool[1] = $urandom_range(255);
         if ($urandom_range(4) != 0) send_noise(rrc_pkg::OP_CLEAR);
         n = ($urandom_range(9) == 0) ? $urandom_range(30, 35) : $urandom_range(1, 8);
         for (int i = 0; i < n; i++) add_random();
         k = $urandom_range(3, 30);
         for (int i = 0; i < k; i++) begin
            if ($urandom_range(19) == 0) send_noise(rrc_pkg::OP_NONE);
            if ($urandom_range(29) == 0) add_random();
            send_noise(rrc_pkg::OP_FETCH);
         end
      end

      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
